// ===== hdl/lcv_pkg.sv =====
// shared types, constants and lookup functions of the location code validator
package lcv_pkg;

	localparam int MAX_LEN = 64;
	localparam int CIDX_W = $clog2(MAX_LEN + 1);
	localparam int EPOS_W = 6;
	localparam int DRUN_W = 7;
	localparam int CQ_DEPTH = 4;
	localparam int CQ_PTR_W = $clog2(CQ_DEPTH);
	localparam int CQ_CNT_W = $clog2(CQ_DEPTH + 1);
	localparam int NUM_LETTERS = 13;

	localparam logic [2:0] ST_VALID = 3'd0;
	localparam logic [2:0] ST_BLANK = 3'd1;
	localparam logic [2:0] ST_STRUCT = 3'd2;
	localparam logic [2:0] ST_CODE = 3'd3;
	localparam logic [2:0] ST_ORDER = 3'd4;

	localparam logic [12:0] CODE_ENABLE_RST = 13'h1FFF;
	localparam logic [3:0] LETTER_NONE = 4'd13;

	localparam logic [7:0] CH_N = 8'h4E;
	localparam logic [7:0] CH_P = 8'h50;
	localparam logic [7:0] CH_C = 8'h43;
	localparam logic [7:0] CH_S = 8'h53;
	localparam logic [7:0] CH_U = 8'h55;
	localparam logic [7:0] CH_M = 8'h4D;
	localparam logic [7:0] CH_L = 8'h4C;
	localparam logic [7:0] CH_I = 8'h49;
	localparam logic [7:0] CH_O = 8'h4F;
	localparam logic [7:0] CH_F = 8'h46;
	localparam logic [7:0] CH_A = 8'h41;
	localparam logic [7:0] CH_H = 8'h48;
	localparam logic [7:0] CH_V = 8'h56;
	localparam logic [7:0] CH_0 = 8'h30;
	localparam logic [7:0] CH_9 = 8'h39;
	localparam logic [7:0] CH_SP = 8'h20;
	localparam logic [7:0] CH_TAB = 8'h09;
	localparam logic [7:0] CH_CR = 8'h0D;

	typedef struct packed {
		logic       has_char;
		logic       close;
		logic       is_space;
		logic       is_digit;
		logic       letter_ok;
		logic       grp_valid;
		logic [1:0] grp;
		logic [7:0] ch;
	} cls_t;

	typedef struct packed {
		logic [2:0]        status;
		logic [EPOS_W-1:0] error_position;
		logic [3:0]        groups_seen;
		logic [DRUN_W-1:0] digit_count;
	} res_t;

	function automatic logic [3:0] letter_index(input logic [7:0] ch);
		logic [3:0] idx;
		case (ch)
			CH_N: idx = 4'd0;
			CH_P: idx = 4'd1;
			CH_C: idx = 4'd2;
			CH_S: idx = 4'd3;
			CH_U: idx = 4'd4;
			CH_M: idx = 4'd5;
			CH_L: idx = 4'd6;
			CH_I: idx = 4'd7;
			CH_O: idx = 4'd8;
			CH_F: idx = 4'd9;
			CH_A: idx = 4'd10;
			CH_H: idx = 4'd11;
			CH_V: idx = 4'd12;
			default: idx = LETTER_NONE;
		endcase
		return idx;
	endfunction

	// group code 0..3, bit 2 set for no group
	function automatic logic [2:0] letter_group(input logic [3:0] idx);
		logic [2:0] g;
		case (idx)
			4'd1, 4'd2, 4'd3: g = 3'd0;
			4'd4, 4'd5, 4'd6: g = 3'd1;
			4'd7, 4'd8: g = 3'd2;
			4'd9, 4'd10: g = 3'd3;
			default: g = 3'd4;
		endcase
		return g;
	endfunction

endpackage

// ===== hdl/lcv_front.sv =====
// front end: code enable register and character classification
module lcv_front import lcv_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        code_enable_we,
	input  logic [12:0] code_enable,
	input  logic [7:0]  char_in,
	input  logic        is_empty,
	input  logic        last_char,
	output cls_t        cls
);

	logic [12:0] code_enable_q;
	logic [15:0] en_ext;
	logic [3:0]  idx;
	logic [2:0]  grp;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			code_enable_q <= CODE_ENABLE_RST;
		end else if (code_enable_we) begin
			code_enable_q <= code_enable;
		end
	end

	assign en_ext = {3'b000, code_enable_q};
	assign idx = letter_index(char_in);
	assign grp = letter_group(idx);

	always_comb begin
		cls.has_char = !is_empty;
		cls.close = is_empty || last_char;
		cls.is_space = (char_in == CH_SP) || ((char_in >= CH_TAB) && (char_in <= CH_CR));
		cls.is_digit = (char_in >= CH_0) && (char_in <= CH_9);
		cls.letter_ok = (idx != LETTER_NONE) && en_ext[idx];
		cls.grp_valid = !grp[2];
		cls.grp = grp[1:0];
		cls.ch = char_in;
	end

endmodule

// ===== hdl/lcv_cmdq.sv =====
// queue of classified characters between front and back
module lcv_cmdq import lcv_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cls_t wdata,
	output logic full,
	input  logic pop,
	output logic valid,
	output cls_t rdata
);

	cls_t                mem_q [CQ_DEPTH];
	logic [CQ_PTR_W-1:0] wptr_q;
	logic [CQ_PTR_W-1:0] rptr_q;
	logic [CQ_CNT_W-1:0] cnt_q;
	logic                do_push;
	logic                do_pop;

	assign full = (cnt_q == CQ_CNT_W'(CQ_DEPTH));
	assign valid = (cnt_q != '0);
	assign do_push = push && !full;
	assign do_pop = pop && valid;
	assign rdata = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wptr_q <= wptr_q + 1'b1;
			end
			if (do_pop) begin
				rptr_q <= rptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CQ_CNT_W'(CQ_DEPTH))
		else $error("command queue count out of range");

	a_cnt_up: assert property (@(posedge clk) disable iff (!arst_n)
		(do_push && !do_pop) |=> (cnt_q == $past(cnt_q) + 1'b1))
		else $error("command queue count did not follow push");

	a_ptr_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q != CQ_CNT_W'(CQ_DEPTH) && cnt_q != '0)
			|-> (wptr_q - rptr_q == cnt_q[CQ_PTR_W-1:0]))
		else $error("command queue pointers disagree with count");

endmodule

// ===== hdl/lcv_back.sv =====
// back end: per-string rule checking and result buffer
module lcv_back import lcv_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       rec_valid,
	input  cls_t       rec,
	output logic       rec_pop,
	output logic       res_empty,
	input  logic       res_pop,
	output res_t       res
);

	logic [CIDX_W-1:0] char_index_q, char_index_n;
	logic              digits_started_q, digits_started_n;
	logic              prev_was_digit_q, prev_was_digit_n;
	logic              letters_started_q, letters_started_n;
	logic [3:0]        group_used_q, group_used_n;
	logic [7:0]        prev_char_q, prev_char_n;
	logic              all_ws_q, all_ws_n;
	logic [2:0]        ferr_q, ferr_n;
	logic [EPOS_W-1:0] fidx_q, fidx_n;
	logic [DRUN_W-1:0] drun_q, drun_n;

	res_t        obuf_q [2];
	logic        owptr_q;
	logic        orptr_q;
	logic [1:0]  ocnt_q;
	logic        out_space;
	logic        res_push;
	logic        res_take;
	res_t        res_new;
	logic [3:0]  gbit;

	assign res_take = res_pop && (ocnt_q != 2'd0);
	assign out_space = (ocnt_q != 2'd2) || res_take;
	assign rec_pop = rec_valid && (!rec.close || out_space);
	assign res_push = rec_pop && rec.close;
	assign res_empty = (ocnt_q == 2'd0);
	assign res = obuf_q[orptr_q];
	assign gbit = 4'b0001 << rec.grp;

	always_comb begin
		char_index_n = char_index_q;
		digits_started_n = digits_started_q;
		prev_was_digit_n = prev_was_digit_q;
		letters_started_n = letters_started_q;
		group_used_n = group_used_q;
		prev_char_n = prev_char_q;
		all_ws_n = all_ws_q;
		ferr_n = ferr_q;
		fidx_n = fidx_q;
		drun_n = drun_q;
		if (rec.has_char) begin
			if (!rec.is_space) begin
				all_ws_n = 1'b0;
			end
			if (char_index_q < CIDX_W'(MAX_LEN)) begin
				char_index_n = char_index_q + 1'b1;
			end
			if (ferr_q == ST_VALID) begin
				if (char_index_q >= CIDX_W'(MAX_LEN)) begin
					ferr_n = ST_STRUCT;
					fidx_n = char_index_q[EPOS_W-1:0];
				end else if (rec.is_digit) begin
					if ((!digits_started_q && char_index_q != '0) ||
						(digits_started_q && !prev_was_digit_q)) begin
						ferr_n = ST_STRUCT;
						fidx_n = char_index_q[EPOS_W-1:0];
					end else begin
						digits_started_n = 1'b1;
						prev_was_digit_n = 1'b1;
						if (drun_q != {DRUN_W{1'b1}}) begin
							drun_n = drun_q + 1'b1;
						end
						prev_char_n = rec.ch;
					end
				end else if (!rec.letter_ok) begin
					ferr_n = ST_CODE;
					fidx_n = char_index_q[EPOS_W-1:0];
				end else if (rec.grp_valid && ((group_used_q & gbit) != 4'b0000)) begin
					ferr_n = ST_STRUCT;
					fidx_n = char_index_q[EPOS_W-1:0];
				end else begin
					if (rec.grp_valid) begin
						group_used_n = group_used_q | gbit;
					end
					if (rec.grp_valid && letters_started_q && char_index_q != '0 &&
						!prev_was_digit_q && rec.ch < prev_char_q) begin
						ferr_n = ST_ORDER;
						fidx_n = char_index_q[EPOS_W-1:0];
					end else begin
						letters_started_n = 1'b1;
						prev_was_digit_n = 1'b0;
						prev_char_n = rec.ch;
					end
				end
			end
		end
		if (all_ws_n) begin
			res_new.status = ST_BLANK;
			res_new.error_position = '0;
			res_new.groups_seen = '0;
			res_new.digit_count = '0;
		end else begin
			res_new.status = ferr_n;
			res_new.error_position = (ferr_n != ST_VALID) ? fidx_n : '0;
			res_new.groups_seen = group_used_n;
			res_new.digit_count = drun_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			char_index_q <= '0;
			digits_started_q <= 1'b0;
			prev_was_digit_q <= 1'b0;
			letters_started_q <= 1'b0;
			group_used_q <= '0;
			prev_char_q <= '0;
			all_ws_q <= 1'b1;
			ferr_q <= ST_VALID;
			fidx_q <= '0;
			drun_q <= '0;
		end else if (rec_pop) begin
			if (rec.close) begin
				char_index_q <= '0;
				digits_started_q <= 1'b0;
				prev_was_digit_q <= 1'b0;
				letters_started_q <= 1'b0;
				group_used_q <= '0;
				prev_char_q <= '0;
				all_ws_q <= 1'b1;
				ferr_q <= ST_VALID;
				fidx_q <= '0;
				drun_q <= '0;
			end else begin
				char_index_q <= char_index_n;
				digits_started_q <= digits_started_n;
				prev_was_digit_q <= prev_was_digit_n;
				letters_started_q <= letters_started_n;
				group_used_q <= group_used_n;
				prev_char_q <= prev_char_n;
				all_ws_q <= all_ws_n;
				ferr_q <= ferr_n;
				fidx_q <= fidx_n;
				drun_q <= drun_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (res_push) begin
			obuf_q[owptr_q] <= res_new;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			owptr_q <= 1'b0;
			orptr_q <= 1'b0;
			ocnt_q <= 2'd0;
		end else begin
			if (res_push) begin
				owptr_q <= !owptr_q;
			end
			if (res_take) begin
				orptr_q <= !orptr_q;
			end
			if (res_push && !res_take) begin
				ocnt_q <= ocnt_q + 1'b1;
			end else if (res_take && !res_push) begin
				ocnt_q <= ocnt_q - 1'b1;
			end
		end
	end

	a_obuf_bound: assert property (@(posedge clk) disable iff (!arst_n)
		ocnt_q != 2'd3)
		else $error("result buffer overflow");

	a_close_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(rec_pop && rec.close) |=> (char_index_q == '0 && all_ws_q && ferr_q == ST_VALID))
		else $error("string state not cleared after close");

	a_first_error_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(rec_pop && !rec.close && ferr_q != ST_VALID)
			|=> (ferr_q == $past(ferr_q) && fidx_q == $past(fidx_q)))
		else $error("first error overwritten");

endmodule

// ===== hdl/location_code_validator.sv =====
// top level of the location code validator
//
//   port group           direction  transfer when
//   char_in/is_empty/    in         push && !full
//     last_char
//   status/error_pos/    out        pop && !empty
//     groups/digits
//   code_enable          cfg        code_enable_we
//
// one character per cycle sustained unless the checker halts (below); the rule
// checker retires one queued character a cycle, and with an empty result buffer
// a result shows on the outputs in the cycle after the closing item is taken
// reset: code_enable 0x1FFF, both queues empty, string state cleared
// a four deep character queue absorbs stalls; the checker halts on a
// closing item only while both result buffer slots are occupied and none
// is taken in that cycle
module location_code_validator import lcv_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        code_enable_we,
	input  logic [12:0] code_enable,
	input  logic        push,
	output logic        full,
	input  logic [7:0]  char_in,
	input  logic        is_empty,
	input  logic        last_char,
	output logic        empty,
	input  logic        pop,
	output logic [2:0]  status,
	output logic [5:0]  error_position,
	output logic [3:0]  groups_seen,
	output logic [6:0]  digit_count
);

	cls_t cls;
	cls_t rec;
	logic rec_valid;
	logic rec_pop;
	res_t res;

	lcv_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.code_enable_we (code_enable_we),
		.code_enable    (code_enable),
		.char_in        (char_in),
		.is_empty       (is_empty),
		.last_char      (last_char),
		.cls            (cls)
	);

	lcv_cmdq u_cmdq (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (cls),
		.full   (full),
		.pop    (rec_pop),
		.valid  (rec_valid),
		.rdata  (rec)
	);

	lcv_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.rec_valid (rec_valid),
		.rec       (rec),
		.rec_pop   (rec_pop),
		.res_empty (empty),
		.res_pop   (pop),
		.res       (res)
	);

	assign status = res.status;
	assign error_position = res.error_position;
	assign groups_seen = res.groups_seen;
	assign digit_count = res.digit_count;

endmodule
